### rtl/corc_pkg.sv
// ----------------------------------------------------------------------------
// corc_pkg
// Shared types, constants and the CORDIC arctangent table for the
// circle versus oriented rectangle collision pipeline.
// ----------------------------------------------------------------------------
package corc_pkg;

  localparam logic signed [31:0] CORDIC_X0  = 32'sd163008219;
  localparam int                 TRIG_BITS  = 28;
  localparam int                 SQRT_STEPS = 32;
  localparam int                 DIV_STEPS  = 33;
  localparam int                 MAX_CORDIC = 24;

  // sideband along the CORDIC cells
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [29:0]        hw;
    logic [29:0]        hh;
    logic [30:0]        r;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               neg;
  } corc_cside_t;

  // sideband along the square root cells
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        r;
    logic signed [33:0] bx;
    logic signed [33:0] by;
    logic               ovl;
    logic               pok;
  } corc_sside_t;

  // sideband along the divider cells
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               bxn;
    logic               byn;
    logic               ovl;
    logic               psh;
  } corc_dside_t;

  // atan(2^-i) as a fraction of a full turn, 32-bit binary angle
  function automatic logic [31:0] corc_atan(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2F9;
      15:      v = 32'h0000_517C;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A2F;
      19:      v = 32'h0000_0517;
      20:      v = 32'h0000_028B;
      21:      v = 32'h0000_0145;
      22:      v = 32'h0000_00A2;
      23:      v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

### rtl/corc_if.sv
// ----------------------------------------------------------------------------
// corc_in_if / corc_out_if
// Valid/ready channels for circle-rectangle pairs and collision results.
// ----------------------------------------------------------------------------
interface corc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] circle_x;
  logic signed [31:0] circle_y;
  logic [30:0]        radius;
  logic signed [31:0] rect_x;
  logic signed [31:0] rect_y;
  logic [30:0]        rect_width;
  logic [30:0]        rect_height;
  logic [15:0]        rect_angle;

  modport source (output valid, circle_x, circle_y, radius, rect_x, rect_y,
                  rect_width, rect_height, rect_angle, input ready);
  modport sink   (input valid, circle_x, circle_y, radius, rect_x, rect_y,
                  rect_width, rect_height, rect_angle, output ready);
endinterface

interface corc_out_if;
  logic               valid;
  logic               ready;
  logic               overlaps;
  logic               pushed;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;

  modport source (output valid, overlaps, pushed, new_x, new_y, input ready);
  modport sink   (input valid, overlaps, pushed, new_x, new_y, output ready);
endinterface

### rtl/circle_oriented_rect_collide_top.sv
// ----------------------------------------------------------------------------
// circle_oriented_rect_collide_top
// Circle versus rotated rectangle test with push-out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one circle/rectangle pair per item (valid/ready).
//   out_ch : one result item per input item, same order (valid/ready).
//   Throughput is one item per cycle when out_ch is not stalled. The row is:
//   the input register, the CORDIC cell row, six multiply/clamp stages,
//   a 32-cell square root row (distance and ray length side by side),
//   a product stage, a rounding stage, a 33-cell divider row and the
//   output register.
//   The whole row advances together; when a result sits in the output
//   register and out_ch.ready is low, the row holds and in_ch.ready drops
//   in the same cycle. Items are taken again as soon as the result leaves.
//   Reset clears all item valid flags; no result comes out until an item
//   has gone through. The block has no state between items.
// ----------------------------------------------------------------------------
module circle_oriented_rect_collide_top
  import corc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  corc_in_if.sink    in_ch,
  corc_out_if.source out_ch
);

  localparam int NC  = CORDIC_STAGES;
  localparam int LAT = NC + 75;

  logic [LAT-1:0] vld_r;
  logic           en;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---- stage A: offsets, half extents, angle fold
  logic [31:0]        zu;
  logic               aneg;
  logic signed [33:0] a_z_r;
  corc_cside_t        cside_r [0:NC];

  assign aneg = (in_ch.rect_angle[15:14] == 2'd1) || (in_ch.rect_angle[15:14] == 2'd2);
  assign zu   = {in_ch.rect_angle ^ {aneg, 15'd0}, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      a_z_r          <= 34'($signed(zu));
      cside_r[0].dx  <= 33'(in_ch.circle_x) - 33'(in_ch.rect_x);
      cside_r[0].dy  <= 33'(in_ch.circle_y) - 33'(in_ch.rect_y);
      cside_r[0].hw  <= in_ch.rect_width[30:1];
      cside_r[0].hh  <= in_ch.rect_height[30:1];
      cside_r[0].r   <= in_ch.radius;
      cside_r[0].cx  <= in_ch.circle_x;
      cside_r[0].cy  <= in_ch.circle_y;
      cside_r[0].neg <= aneg;
      for (int k = 0; k < NC; k++) begin
        cside_r[k+1] <= cside_r[k];
      end
    end
  end

  // ---- CORDIC cell row
  logic signed [31:0] cx_w [0:NC];
  logic signed [31:0] cy_w [0:NC];
  logic signed [33:0] cz_w [0:NC];

  assign cx_w[0] = CORDIC_X0;
  assign cy_w[0] = '0;
  assign cz_w[0] = a_z_r;

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    corc_cordic_cell #(.IDX(k)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (cx_w[k]),
      .y_i (cy_w[k]),
      .z_i (cz_w[k]),
      .x_o (cx_w[k+1]),
      .y_o (cy_w[k+1]),
      .z_o (cz_w[k+1])
    );
  end

  // ---- M1: rotate into box frame, products
  logic signed [31:0] cc;
  logic signed [31:0] ss;
  logic signed [32:0] ddx;
  logic signed [32:0] ddy;
  logic signed [64:0] m_cdx_r, m_sdy_r, m_sdx_r, m_cdy_r;
  logic signed [31:0] m_c_r, m_s_r, m_cx_r, m_cy_r;
  logic [29:0]        m_hw_r, m_hh_r;
  logic [30:0]        m_r_r;

  assign cc  = cside_r[NC].neg ? -cx_w[NC] : cx_w[NC];
  assign ss  = cside_r[NC].neg ? -cy_w[NC] : cy_w[NC];
  assign ddx = cside_r[NC].dx;
  assign ddy = cside_r[NC].dy;

  always_ff @(posedge clk) begin
    if (en) begin
      m_cdx_r <= cc * ddx;
      m_sdy_r <= ss * ddy;
      m_sdx_r <= ss * ddx;
      m_cdy_r <= cc * ddy;
      m_c_r   <= cc;
      m_s_r   <= ss;
      m_cx_r  <= cside_r[NC].cx;
      m_cy_r  <= cside_r[NC].cy;
      m_hw_r  <= cside_r[NC].hw;
      m_hh_r  <= cside_r[NC].hh;
      m_r_r   <= cside_r[NC].r;
    end
  end

  // ---- M2: sum and round
  logic signed [65:0] lsx, lsy;
  logic signed [37:0] l_x_r, l_y_r;
  logic signed [31:0] l_c_r, l_s_r, l_cx_r, l_cy_r;
  logic [29:0]        l_hw_r, l_hh_r;
  logic [30:0]        l_r_r;

  assign lsx = 66'(m_cdx_r) - 66'(m_sdy_r) + (66'sd1 <<< (TRIG_BITS - 1));
  assign lsy = 66'(m_sdx_r) + 66'(m_cdy_r) + (66'sd1 <<< (TRIG_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      l_x_r  <= 38'(lsx >>> TRIG_BITS);
      l_y_r  <= 38'(lsy >>> TRIG_BITS);
      l_c_r  <= m_c_r;
      l_s_r  <= m_s_r;
      l_cx_r <= m_cx_r;
      l_cy_r <= m_cy_r;
      l_hw_r <= m_hw_r;
      l_hh_r <= m_hh_r;
      l_r_r  <= m_r_r;
    end
  end

  // ---- C: clamp to box, ray to nearest point
  logic signed [37:0] hws, hhs, clx, cly;
  logic signed [38:0] rxw, ryw;
  logic               farw;
  logic signed [31:0] k_rx_r, k_ry_r, k_c_r, k_s_r, k_cx_r, k_cy_r;
  logic [30:0]        k_r_r;
  logic               k_far_r;

  assign hws  = $signed({8'd0, l_hw_r});
  assign hhs  = $signed({8'd0, l_hh_r});
  assign clx  = (l_x_r < -hws) ? -hws : ((l_x_r > hws) ? hws : l_x_r);
  assign cly  = (l_y_r < -hhs) ? -hhs : ((l_y_r > hhs) ? hhs : l_y_r);
  assign rxw  = 39'(clx) - 39'(l_x_r);
  assign ryw  = 39'(cly) - 39'(l_y_r);
  assign farw = (rxw <= -39'sd2147483648) || (rxw >= 39'sd2147483648) ||
                (ryw <= -39'sd2147483648) || (ryw >= 39'sd2147483648);

  always_ff @(posedge clk) begin
    if (en) begin
      k_rx_r  <= rxw[31:0];
      k_ry_r  <= ryw[31:0];
      k_far_r <= farw;
      k_c_r   <= l_c_r;
      k_s_r   <= l_s_r;
      k_cx_r  <= l_cx_r;
      k_cy_r  <= l_cy_r;
      k_r_r   <= l_r_r;
    end
  end

  // ---- Q: squares and back-rotation products
  logic signed [63:0] q_sx_r, q_sy_r, q_b1_r, q_b2_r, q_b3_r, q_b4_r;
  logic [61:0]        q_r2_r;
  logic signed [31:0] q_cx_r, q_cy_r;
  logic [30:0]        q_r_r;
  logic               q_far_r, q_nz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_sx_r  <= k_rx_r * k_rx_r;
      q_sy_r  <= k_ry_r * k_ry_r;
      q_r2_r  <= k_r_r * k_r_r;
      q_b1_r  <= k_rx_r * k_c_r;
      q_b2_r  <= k_ry_r * k_s_r;
      q_b3_r  <= k_ry_r * k_c_r;
      q_b4_r  <= k_rx_r * k_s_r;
      q_far_r <= k_far_r;
      q_nz_r  <= (k_rx_r != '0) || (k_ry_r != '0);
      q_cx_r  <= k_cx_r;
      q_cy_r  <= k_cy_r;
      q_r_r   <= k_r_r;
    end
  end

  // ---- D: distance squared, overlap, rotated-back ray
  logic [63:0]        d2w;
  logic               ovlw;
  logic signed [64:0] bsx, bsy;
  logic [63:0]        d_d2_r;
  corc_sside_t        d_side_r;

  assign d2w  = 64'(q_sx_r) + 64'(q_sy_r);
  assign ovlw = !q_far_r && ({2'b00, q_r2_r} > d2w);
  assign bsx  = 65'(q_b1_r) + 65'(q_b2_r) + (65'sd1 <<< (TRIG_BITS - 1));
  assign bsy  = 65'(q_b3_r) - 65'(q_b4_r) + (65'sd1 <<< (TRIG_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      d_d2_r       <= d2w;
      d_side_r.cx  <= q_cx_r;
      d_side_r.cy  <= q_cy_r;
      d_side_r.r   <= q_r_r;
      d_side_r.bx  <= 34'(bsx >>> TRIG_BITS);
      d_side_r.by  <= 34'(bsy >>> TRIG_BITS);
      d_side_r.ovl <= ovlw;
      d_side_r.pok <= ovlw && q_nz_r;
    end
  end

  // ---- E: ray length squared
  logic signed [33:0] ebx, eby;
  logic signed [67:0] el2;
  logic [63:0]        e_d2_r, e_l2_r;
  corc_sside_t        sside_r [0:SQRT_STEPS];

  assign ebx = d_side_r.bx;
  assign eby = d_side_r.by;
  assign el2 = 68'(ebx * ebx) + 68'(eby * eby);

  always_ff @(posedge clk) begin
    if (en) begin
      e_d2_r     <= d_d2_r;
      e_l2_r     <= el2[63:0];
      sside_r[0] <= d_side_r;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sside_r[k+1] <= sside_r[k];
      end
    end
  end

  // ---- square root cell rows: distance and ray length
  logic [63:0] sd_n [0:SQRT_STEPS];
  logic [63:0] sd_q [0:SQRT_STEPS];
  logic [63:0] sl_n [0:SQRT_STEPS];
  logic [63:0] sl_q [0:SQRT_STEPS];

  assign sd_n[0] = e_d2_r;
  assign sd_q[0] = '0;
  assign sl_n[0] = e_l2_r;
  assign sl_q[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    corc_sqrt_cell #(.IDX(k)) u_dist (
      .clk   (clk),
      .en    (en),
      .n_i   (sd_n[k]),
      .res_i (sd_q[k]),
      .n_o   (sd_n[k+1]),
      .res_o (sd_q[k+1])
    );
    corc_sqrt_cell #(.IDX(k)) u_len (
      .clk   (clk),
      .en    (en),
      .n_i   (sl_n[k]),
      .res_i (sl_q[k]),
      .n_o   (sl_n[k+1]),
      .res_o (sl_q[k+1])
    );
  end

  // ---- P: overlap depth, step magnitudes
  corc_sside_t        ps;
  logic signed [32:0] ovw;
  logic               ovpos;
  logic [31:0]        lenw;
  logic [33:0]        magx, magy;
  logic [64:0]        prx, pry;
  logic [63:0]        p_px_r, p_py_r;
  logic [31:0]        p_len_r;
  corc_dside_t        p_side_r;

  assign ps    = sside_r[SQRT_STEPS];
  assign lenw  = sl_q[SQRT_STEPS][31:0];
  assign ovw   = $signed({2'b00, ps.r}) - $signed({1'b0, sd_q[SQRT_STEPS][31:0]});
  assign ovpos = !ovw[32] && (ovw != '0);
  assign magx  = ps.bx[33] ? 34'(-ps.bx) : 34'(ps.bx);
  assign magy  = ps.by[33] ? 34'(-ps.by) : 34'(ps.by);
  assign prx   = magx * ovw[30:0];
  assign pry   = magy * ovw[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_px_r       <= prx[63:0];
      p_py_r       <= pry[63:0];
      p_len_r      <= lenw;
      p_side_r.cx  <= ps.cx;
      p_side_r.cy  <= ps.cy;
      p_side_r.bxn <= ps.bx[33];
      p_side_r.byn <= ps.by[33];
      p_side_r.ovl <= ps.ovl;
      p_side_r.psh <= ps.pok && ovpos && (lenw != '0);
    end
  end

  // ---- N: rounding offset for the divide
  logic [63:0] n_nx_r, n_ny_r;
  logic [31:0] n_len_r;
  corc_dside_t dside_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      n_nx_r     <= p_px_r + 64'(p_len_r >> 1);
      n_ny_r     <= p_py_r + 64'(p_len_r >> 1);
      n_len_r    <= p_len_r;
      dside_r[0] <= p_side_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dside_r[k+1] <= dside_r[k];
      end
    end
  end

  // ---- divider cell rows, quotient MSB first
  logic [63:0] vx_r [0:DIV_STEPS];
  logic [63:0] vy_r [0:DIV_STEPS];
  logic [31:0] vxd [0:DIV_STEPS];
  logic [31:0] vyd [0:DIV_STEPS];
  logic [32:0] vxq [0:DIV_STEPS];
  logic [32:0] vyq [0:DIV_STEPS];

  assign vx_r[0] = n_nx_r;
  assign vy_r[0] = n_ny_r;
  assign vxd[0]  = n_len_r;
  assign vyd[0]  = n_len_r;
  assign vxq[0]  = '0;
  assign vyq[0]  = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    corc_div_cell #(.SH(DIV_STEPS - 1 - k)) u_x (
      .clk   (clk),
      .en    (en),
      .rem_i (vx_r[k]),
      .dv_i  (vxd[k]),
      .q_i   (vxq[k]),
      .rem_o (vx_r[k+1]),
      .dv_o  (vxd[k+1]),
      .q_o   (vxq[k+1])
    );
    corc_div_cell #(.SH(DIV_STEPS - 1 - k)) u_y (
      .clk   (clk),
      .en    (en),
      .rem_i (vy_r[k]),
      .dv_i  (vyd[k]),
      .q_i   (vyq[k]),
      .rem_o (vy_r[k+1]),
      .dv_o  (vyd[k+1]),
      .q_o   (vyq[k+1])
    );
  end

  // ---- output register: apply step, saturate
  corc_dside_t        fs;
  logic signed [33:0] qx, qy;
  logic signed [34:0] nxw, nyw;
  logic signed [31:0] nxs, nys;
  logic               o_ovl_r, o_psh_r;
  logic signed [31:0] o_x_r, o_y_r;
  logic               unused_w;

  assign fs  = dside_r[DIV_STEPS];
  assign qx  = fs.bxn ? -$signed({1'b0, vxq[DIV_STEPS]}) : $signed({1'b0, vxq[DIV_STEPS]});
  assign qy  = fs.byn ? -$signed({1'b0, vyq[DIV_STEPS]}) : $signed({1'b0, vyq[DIV_STEPS]});
  assign nxw = 35'(fs.cx) - 35'(qx);
  assign nyw = 35'(fs.cy) - 35'(qy);
  assign nxs = (nxw > 35'sd2147483647) ? 32'sh7FFF_FFFF :
               ((nxw < -35'sd2147483648) ? 32'sh8000_0000 : nxw[31:0]);
  assign nys = (nyw > 35'sd2147483647) ? 32'sh7FFF_FFFF :
               ((nyw < -35'sd2147483648) ? 32'sh8000_0000 : nyw[31:0]);
  assign unused_w = ^{cz_w[NC], vx_r[DIV_STEPS], vy_r[DIV_STEPS], vxd[DIV_STEPS],
                      vyd[DIV_STEPS], sd_n[SQRT_STEPS], sl_n[SQRT_STEPS],
                      sd_q[SQRT_STEPS][63:32], sl_q[SQRT_STEPS][63:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      o_ovl_r <= fs.ovl;
      o_psh_r <= fs.psh;
      o_x_r   <= fs.psh ? nxs : fs.cx;
      o_y_r   <= fs.psh ? nys : fs.cy;
    end
  end

  assign out_ch.valid    = vld_r[LAT-1];
  assign out_ch.overlaps = o_ovl_r;
  assign out_ch.pushed   = o_psh_r;
  assign out_ch.new_x    = o_x_r;
  assign out_ch.new_y    = o_y_r;

  // ---- checks
  a_push_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.pushed || out_ch.overlaps))
    else $error("pushed result without overlap");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

endmodule

### rtl/corc_cordic_cell.sv
// ----------------------------------------------------------------------------
// corc_cordic_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module corc_cordic_cell
  import corc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic signed [33:0] z_i,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [33:0] z_o
);

  logic signed [33:0] at;

  assign at = $signed({2'b00, corc_atan(IDX)});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[33]) begin
        x_o <= x_i - (y_i >>> IDX);
        y_o <= y_i + (x_i >>> IDX);
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + (y_i >>> IDX);
        y_o <= y_i - (x_i >>> IDX);
        z_o <= z_i + at;
      end
    end
  end

endmodule

### rtl/corc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// corc_sqrt_cell
// One bit of a 64-bit floor square root, digit recurrence, registered.
// ----------------------------------------------------------------------------
module corc_sqrt_cell
  import corc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_i,
  input  logic [63:0] res_i,
  output logic [63:0] n_o,
  output logic [63:0] res_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

  logic [64:0] trial;
  assign trial = {1'b0, res_i} + {1'b0, BIT};

  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, n_i} >= trial) begin
        n_o   <= n_i - trial[63:0];
        res_o <= (res_i >> 1) + BIT;
      end else begin
        n_o   <= n_i;
        res_o <= res_i >> 1;
      end
    end
  end

endmodule

### rtl/corc_div_cell.sv
// ----------------------------------------------------------------------------
// corc_div_cell
// One quotient bit of a restoring divide, 64-bit dividend, registered.
// ----------------------------------------------------------------------------
module corc_div_cell
  import corc_pkg::*;
#(
  parameter int SH = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_i,
  input  logic [31:0] dv_i,
  input  logic [32:0] q_i,
  output logic [63:0] rem_o,
  output logic [31:0] dv_o,
  output logic [32:0] q_o
);

  logic [64:0] dsh;
  assign dsh = {33'd0, dv_i} << SH;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_o <= dv_i;
      if ({1'b0, rem_i} >= dsh) begin
        rem_o <= rem_i - dsh[63:0];
        q_o   <= {q_i[31:0], 1'b1};
      end else begin
        rem_o <= rem_i;
        q_o   <= {q_i[31:0], 1'b0};
      end
    end
  end

endmodule

### test/tb_circle_oriented_rect_collide_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_oriented_rect_collide_top
// Drives circle/rectangle pairs through the collision pipeline and checks
// every result item, in order, against a bit-exact fixed point predictor
// (CORDIC rotation, clamp, square roots, rounded push-out, saturation).
// Directed corner cases come first, then random pairs with random idling on
// both sides, a long output stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_circle_oriented_rect_collide_top;
  import corc_pkg::*;

  localparam int     STAGES    = 16;
  localparam int     LATENCY   = STAGES + 75;
  localparam int     MAX_CYCLES = 400000;
  localparam longint I32_MIN   = -64'sd2147483648;
  localparam longint I32_MAX   = 64'sd2147483647;

  typedef struct packed {
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic [30:0]        radius;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [30:0]        rect_width;
    logic [30:0]        rect_height;
    logic [15:0]        rect_angle;
  } pair_t;

  typedef struct packed {
    logic               overlaps;
    logic               pushed;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
  } outcome_t;

  localparam longint TURN_ATAN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  logic clk;
  logic rst_n;

  corc_in_if  in_ch ();
  corc_out_if out_ch ();

  circle_oriented_rect_collide_top #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  outcome_t expected_q[$];
  int       errors = 0;
  int       n_sent = 0;
  int       n_recv = 0;
  int       n_push = 0;
  int       n_ovl  = 0;
  bit       idle_on = 1'b0;
  bit       hold_req = 1'b0;
  longint   cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_q28(longint sum);
    return (sum + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint push_step(longint b, longint ov, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (b < 0) ? longint'(-b) : longint'(b);
    q = (mag * longint'(ov) + len / 2) / len;
    return (b < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic outcome_t collide(pair_t p);
    outcome_t o;
    logic [31:0] zu;
    logic        neg;
    longint x, y, z, tx, ty, c, s;
    longint cx, cy, r, hw, hh, dx, dy, lx, ly, rx, ry, ov, bx, by, nx, ny;
    longint unsigned d2, len;
    cx = p.circle_x;
    cy = p.circle_y;
    r  = longint'(p.radius);
    hw = longint'(p.rect_width >> 1);
    hh = longint'(p.rect_height >> 1);
    zu = {p.rect_angle, 16'h0000};
    neg = (p.rect_angle[15:14] == 2'd1) || (p.rect_angle[15:14] == 2'd2);
    if (neg) zu = zu - 32'h8000_0000;
    z = longint'($signed(zu));
    x = 163008219;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      tx = y >>> i;
      ty = x >>> i;
      if (z >= 0) begin
        x = x - tx; y = y + ty; z = z - TURN_ATAN[i];
      end else begin
        x = x + tx; y = y - ty; z = z + TURN_ATAN[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    dx = cx - longint'(p.rect_x);
    dy = cy - longint'(p.rect_y);
    lx = round_q28(c * dx - s * dy);
    ly = round_q28(s * dx + c * dy);
    rx = clamp64(lx, -hw, hw) - lx;
    ry = clamp64(ly, -hh, hh) - ly;
    nx = cx;
    ny = cy;
    o.overlaps = 1'b0;
    o.pushed = 1'b0;
    if (rx > I32_MIN && rx <= I32_MAX && ry > I32_MIN && ry <= I32_MAX) begin
      d2 = longint'(rx * rx) + longint'(ry * ry);
      o.overlaps = (longint'(r * r) > d2);
      if (o.overlaps && (rx != 0 || ry != 0)) begin
        ov = r - longint'(sqrt_floor(d2));
        bx = round_q28(rx * c + ry * s);
        by = round_q28(ry * c - rx * s);
        len = sqrt_floor(longint'(bx * bx) + longint'(by * by));
        if (ov > 0 && len != 0) begin
          nx = clamp64(cx - push_step(bx, ov, len), I32_MIN, I32_MAX);
          ny = clamp64(cy - push_step(by, ov, len), I32_MIN, I32_MAX);
          o.pushed = 1'b1;
        end
      end
    end
    o.new_x = nx[31:0];
    o.new_y = ny[31:0];
    return o;
  endfunction

  // sender: one item per call, optional idle burst afterwards
  task automatic send_pair(pair_t p);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.circle_x    <= p.circle_x;
    in_ch.circle_y    <= p.circle_y;
    in_ch.radius      <= p.radius;
    in_ch.rect_x      <= p.rect_x;
    in_ch.rect_y      <= p.rect_y;
    in_ch.rect_width  <= p.rect_width;
    in_ch.rect_height <= p.rect_height;
    in_ch.rect_angle  <= p.rect_angle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(collide(p));
    n_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic pair_t noise_pair();
    pair_t p;
    p.circle_x    = $urandom;
    p.circle_y    = $urandom;
    p.radius      = 31'($urandom);
    p.rect_x      = $urandom;
    p.rect_y      = $urandom;
    p.rect_width  = 31'($urandom);
    p.rect_height = 31'($urandom);
    p.rect_angle  = 16'($urandom);
    return p;
  endfunction

  // circle placed near the box so that hits and push-outs are common
  function automatic pair_t near_pair();
    pair_t p;
    int    sc;
    int    ext;
    sc = $urandom_range(4, 24);
    ext = 1 << sc;
    p = noise_pair();
    p.radius      = 31'($urandom_range(0, ext));
    p.rect_width  = 31'($urandom_range(0, 2 * ext));
    p.rect_height = 31'($urandom_range(0, 2 * ext));
    p.circle_x    = p.rect_x + $signed($urandom_range(0, 4 * ext)) - 2 * ext;
    p.circle_y    = p.rect_y + $signed($urandom_range(0, 4 * ext)) - 2 * ext;
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '0;
    send_pair(p);
    // centre inside the box
    p = '0; p.radius = 31'h0001_0000; p.rect_width = 31'h0004_0000;
    p.rect_height = 31'h0004_0000;
    send_pair(p);
    // plain push-out at each quadrant angle, at 45 degrees and just below a full turn
    for (int a = 0; a < 6; a++) begin
      p = '0;
      p.circle_x = 32'sh0003_0000; p.circle_y = 32'sh0000_8000;
      p.radius = 31'h0002_0000;
      p.rect_width = 31'h0004_0000; p.rect_height = 31'h0002_0000;
      p.rect_angle = (a == 5) ? 16'hFFFF : 16'(a * 16384 + (a == 4 ? 8192 : 0));
      send_pair(p);
    end
    // degenerate boxes: point and segment
    p = '0; p.circle_x = 32'sh0000_4000; p.radius = 31'h0001_0000;
    p.rect_width = 31'd1; p.rect_height = 31'd0;
    send_pair(p);
    p.rect_width = 31'h0010_0000; p.rect_height = 31'd1; p.circle_y = 32'sh0000_2000;
    send_pair(p);
    // far ray from extreme coordinates
    p = '0; p.circle_x = 32'sh7FFF_FFFF; p.circle_y = 32'sh7FFF_FFFF;
    p.rect_x = 32'sh8000_0000; p.rect_y = 32'sh8000_0000; p.radius = 31'h7FFF_FFFF;
    p.rect_angle = 16'h2000;
    send_pair(p);
    p.circle_x = 32'sh8000_0000; p.rect_x = 32'sh7FFF_FFFF; p.rect_angle = 16'h0000;
    send_pair(p);
    // all fields with every bit set
    p = '1;
    send_pair(p);
    p.circle_x = 32'sh7FFF_FFFF; p.circle_y = 32'sh7FFF_FFFF;
    p.rect_x = 32'sh7FFF_FFFF; p.rect_y = 32'sh7FFF_FFFF;
    send_pair(p);
    // push that saturates at both ends
    p = '0; p.circle_x = 32'sh7FFF_0000; p.circle_y = 32'sh7FFF_0000;
    p.rect_x = 32'sh7FF0_0000; p.rect_y = 32'sh7FF0_0000;
    p.radius = 31'h4000_0000; p.rect_width = 31'h0002_0000; p.rect_height = 31'h0002_0000;
    send_pair(p);
    p.circle_x = 32'sh8001_0000; p.circle_y = 32'sh8001_0000;
    p.rect_x = 32'sh8010_0000; p.rect_y = 32'sh8010_0000;
    send_pair(p);
    // tiny ray that may round to zero after rotating back
    p = '0; p.circle_x = 32'sh0000_0002; p.radius = 31'd5;
    p.rect_width = 31'd2; p.rect_angle = 16'h1234;
    send_pair(p);
    // radius exactly equal to the distance
    p = '0; p.circle_x = 32'sh0002_0000; p.radius = 31'h0001_0000;
    p.rect_width = 31'h0002_0000; p.rect_height = 31'h0002_0000;
    send_pair(p);
    in_ch.valid <= 1'b0;
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_pair(($urandom_range(0, 4) == 0) ? noise_pair() : near_pair());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(150);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random(100);
    in_ch.valid <= 1'b0;
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    outcome_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.overlaps, out_ch.pushed, out_ch.new_x, out_ch.new_y};
      n_recv++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
      end else begin
        exp = expected_q.pop_front();
        n_ovl += exp.overlaps;
        n_push += exp.pushed;
        if (got.overlaps !== exp.overlaps || got.pushed !== exp.pushed ||
            got.new_x !== exp.new_x || got.new_y !== exp.new_y) begin
          $display("%0t: mismatch expected ovl=%0b psh=%0b x=%0d y=%0d",
                   $time, exp.overlaps, exp.pushed, exp.new_x, exp.new_y);
          $display("%0t:          actual   ovl=%0b psh=%0b x=%0d y=%0d",
                   $time, got.overlaps, got.pushed, got.new_x, got.new_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.circle_x    <= '0;
    in_ch.circle_y    <= '0;
    in_ch.radius      <= '0;
    in_ch.rect_x      <= '0;
    in_ch.rect_y      <= '0;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    in_ch.rect_angle  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_on = 1'b1;
    test_random(250);
    test_backpressure();
    test_full_rate();
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_q.size() != 0) errors++;
    $display("sent %0d items, checked %0d results (%0d overlaps, %0d push-outs)",
             n_sent, n_recv, n_ovl, n_push);
    $display("covered corner cases, random idling, a long output stall, full rate");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### circle_oriented_rect_collide_top.f
rtl/corc_pkg.sv
rtl/corc_if.sv
rtl/corc_cordic_cell.sv
rtl/corc_sqrt_cell.sv
rtl/corc_div_cell.sv
rtl/circle_oriented_rect_collide_top.sv
test/tb_circle_oriented_rect_collide_top.sv
